/* rtl/core/texture_texel_sampler_core_defines.svh */
// Assertion macros shared by the texture sampler checkers.
// They expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TEXTURE_TEXEL_SAMPLER_CORE_DEFINES_SVH
`define TEXTURE_TEXEL_SAMPLER_CORE_DEFINES_SVH

// Consequence must hold in the cycle after the condition, outside reset
`define TTS_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("texture sampler check failed");

// Consequence must hold in the same cycle as the condition, outside reset
`define TTS_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error("texture sampler check failed");

// Next-cycle rule that is also checked while reset is applied
`define TTS_ASSERT_ALWAYS_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) (cond) |=> (conseq)) \
        else $error("texture sampler reset check failed");

`endif

/* rtl/core/tts_pkg.sv */
package tts_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W    = 32;
    localparam int WORD_W     = 16;
    localparam int ARGB_W     = 32;
    localparam int SIZE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Texel index width: a 4-bit size_log2 gives sides up to 2^15
    localparam int IDX_W      = 15;
    // Width used for texel address arithmetic before the store wrap
    localparam int ADDR_SUM_W = 32;

    // Item operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        WRAP_CYL    = 2'd0,
        WRAP_REPEAT = 2'd1,
        WRAP_MIRROR = 2'd2,
        WRAP_CLAMP  = 2'd3
    } t_wrap_mode;

    // Codes 4 to 7 decode to white
    typedef enum logic [2:0] {
        FMT_A1R5G5B5 = 3'd0,
        FMT_X1R5G5B5 = 3'd1,
        FMT_A4R4G4B4 = 3'd2,
        FMT_R5G6B5   = 3'd3
    } t_format;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_U   = 3'd0,
        CFG_WRAP_V   = 3'd1,
        CFG_SIZE     = 3'd2,
        CFG_FORMAT   = 3'd3,
        CFG_TEX_BASE = 3'd4
    } t_cfg_index;

endpackage

/* rtl/core/texture_texel_sampler_core.sv */
// Point-sampled texture fetch with a local texel store (one single-port RAM).
// A sample's ARGB result passes the input stage (fold/scale), the store read and the
// texel decode into the output register; loads give no result. Throughput: one item
// per cycle unless the output stalls, set by the one store access each item makes.
// Reset clears the pipeline valids and config registers; the store is not cleared.
module texture_texel_sampler_core #(
    parameter int TEX_WORDS = 65536,  // power of two, 1024 to 16777216
    parameter int FRAC_BITS = 16      // 12 to 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic signed [tts_pkg::COORD_W-1:0] i_coord_u,
    input  logic signed [tts_pkg::COORD_W-1:0] i_coord_v,
    input  logic [tts_pkg::WORD_W-1:0]       i_load_address,
    input  logic [tts_pkg::WORD_W-1:0]       i_load_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tts_pkg::ARGB_W-1:0]       o_argb
);
    import tts_pkg::*;

    localparam int AW      = $clog2(TEX_WORDS);
    localparam int FOLD_W  = FRAC_BITS + 1;
    localparam int SCALE_W = FOLD_W + IDX_W;
    localparam logic [FOLD_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FOLD_W:0]   FIX_TWO = {2'b10, {FRAC_BITS{1'b0}}};

    // Fold a raw coordinate into 0..1 by wrap mode
    function automatic logic [FOLD_W-1:0] fold_coord(input logic [COORD_W-1:0] raw,
                                                     input t_wrap_mode mode);
        logic [FOLD_W-1:0] c;
        logic [FOLD_W-1:0] res;
        c = raw[FRAC_BITS:0];
        case (mode)
            WRAP_MIRROR: begin
                if (c > FIX_ONE) begin
                    res = FOLD_W'(FIX_TWO - {1'b0, c});
                end else begin
                    res = c;
                end
            end
            WRAP_CLAMP: begin
                if (raw[COORD_W-1]) begin
                    res = '0;
                end else if (raw > COORD_W'(FIX_ONE)) begin
                    res = FIX_ONE;
                end else begin
                    res = c;
                end
            end
            default: res = {1'b0, raw[FRAC_BITS-1:0]};
        endcase
        return res;
    endfunction

    // Scale by the side, drop fraction, mask to the side
    function automatic logic [IDX_W-1:0] texel_index(input logic [FOLD_W-1:0] c,
                                                     input logic [SIZE_W-1:0] s);
        logic [SCALE_W-1:0] scaled;
        logic [IDX_W:0]     mask;
        scaled = {{IDX_W{1'b0}}, c} << s;
        mask   = ({{IDX_W{1'b0}}, 1'b1} << s) - {{IDX_W{1'b0}}, 1'b1};
        return scaled[FRAC_BITS +: IDX_W] & mask[IDX_W-1:0];
    endfunction

    // Expand a stored texel word to ARGB8888
    function automatic logic [ARGB_W-1:0] decode_texel(input logic [WORD_W-1:0] t,
                                                       input t_format f);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (f)
            FMT_A1R5G5B5: begin
                a = {8{t[15]}};
                r = {t[14:10], 3'b000};
                g = {t[9:5], 3'b000};
                b = {t[4:0], 3'b000};
            end
            FMT_X1R5G5B5: begin
                a = 8'hFF;
                r = {t[14:10], 3'b000};
                g = {t[9:5], 3'b000};
                b = {t[4:0], 3'b000};
            end
            FMT_A4R4G4B4: begin
                a = {t[15:12], 4'b0000};
                r = {t[11:8], 4'b0000};
                g = {t[7:4], 4'b0000};
                b = {t[3:0], 4'b0000};
            end
            FMT_R5G6B5: begin
                a = 8'hFF;
                r = {t[15:11], 3'b000};
                g = {t[10:5], 2'b00};
                b = {t[4:0], 3'b000};
            end
            default: begin
                a = 8'hFF;
                r = 8'hFF;
                g = 8'hFF;
                b = 8'hFF;
            end
        endcase
        return {a, r, g, b};
    endfunction

    // Config registers
    t_wrap_mode        r_wrap_u;
    t_wrap_mode        r_wrap_v;
    logic [SIZE_W-1:0] r_size_log2;
    t_format           r_format;
    logic [WORD_W-1:0] r_tex_base;

    // Pipeline registers
    logic              r_s1_valid;
    logic              r_s1_op;
    logic [IDX_W-1:0]  r_s1_x;
    logic [IDX_W-1:0]  r_s1_y;
    logic [WORD_W-1:0] r_s1_ladr;
    logic [WORD_W-1:0] r_s1_ldata;
    logic              r_s2_valid;
    logic [WORD_W-1:0] r_s2_texel;
    logic              r_out_valid;
    logic [ARGB_W-1:0] r_argb;

    // Texel store
    logic [WORD_W-1:0] mem [TEX_WORDS];

    logic                  out_en;
    logic                  s2_en;
    logic                  s1_en;
    logic                  s1_fire;
    logic [IDX_W-1:0]      n_s1_x;
    logic [IDX_W-1:0]      n_s1_y;
    logic [ADDR_SUM_W-1:0] samp_sum;
    logic [ADDR_SUM_W-1:0] load_ext;
    logic [AW-1:0]         mem_addr;
    logic [ARGB_W-1:0]     n_argb;

    // Per-stage advance: a stage moves when it is empty or its successor moves
    assign out_en  = !r_out_valid || i_out_ready;
    assign s2_en   = !r_s2_valid || out_en;
    assign s1_en   = !r_s1_valid || s2_en;
    assign s1_fire = r_s1_valid && s2_en;

    assign o_in_ready  = s1_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_argb      = r_argb;

    // Stage 0: fold and scale coordinates into texel indexes
    assign n_s1_x = texel_index(fold_coord(i_coord_u, r_wrap_u), r_size_log2);
    assign n_s1_y = texel_index(fold_coord(i_coord_v, r_wrap_v), r_size_log2);

    // Stage 1: word address, wrapped to the store size
    assign samp_sum = ADDR_SUM_W'(r_tex_base)
                    + (ADDR_SUM_W'(r_s1_y) << r_size_log2)
                    + ADDR_SUM_W'(r_s1_x);
    assign load_ext = ADDR_SUM_W'(r_s1_ladr);
    assign mem_addr = (r_s1_op == OP_SAMPLE) ? samp_sum[AW-1:0] : load_ext[AW-1:0];

    // Stage 2: decode the texel read out of the store
    assign n_argb = decode_texel(r_s2_texel, r_format);

    // Store access: loads write, samples read (registered read data)
    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_op == OP_LOAD) begin
            mem[mem_addr] <= r_s1_ldata;
        end
        if (s1_fire && r_s1_op == OP_SAMPLE) begin
            r_s2_texel <= mem[mem_addr];
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_u    <= WRAP_CYL;
            r_wrap_v    <= WRAP_CYL;
            r_size_log2 <= '0;
            r_format    <= FMT_A1R5G5B5;
            r_tex_base  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_WRAP_U:   r_wrap_u    <= t_wrap_mode'(i_cfg_data[1:0]);
                    CFG_WRAP_V:   r_wrap_v    <= t_wrap_mode'(i_cfg_data[1:0]);
                    CFG_SIZE:     r_size_log2 <= i_cfg_data[SIZE_W-1:0];
                    CFG_FORMAT:   r_format    <= t_format'(i_cfg_data[2:0]);
                    CFG_TEX_BASE: r_tex_base  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s1_en) begin
                r_s1_valid <= i_in_valid;
            end
            // loads retire at the store write
            if (s2_en) begin
                r_s2_valid <= r_s1_valid && (r_s1_op == OP_SAMPLE);
            end
            if (out_en) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_en && i_in_valid) begin
            r_s1_op    <= i_op;
            r_s1_x     <= n_s1_x;
            r_s1_y     <= n_s1_y;
            r_s1_ladr  <= i_load_address;
            r_s1_ldata <= i_load_data;
        end
        if (out_en && r_s2_valid) begin
            r_argb <= n_argb;
        end
    end

endmodule

/* rtl/core/tts_checker.sv */
`include "texture_texel_sampler_core_defines.svh"

module tts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_argb
);

    // Result held while the sink stalls
    `TTS_ASSERT_NEXT(a_out_valid_hold, o_out_valid && !i_out_ready, o_out_valid)
    `TTS_ASSERT_NEXT(a_argb_hold, o_out_valid && !i_out_ready, $stable(o_argb))

    // Empty output register means the pipeline can take an item
    `TTS_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)
    // A draining output frees the whole pipeline
    `TTS_ASSERT_NOW(a_ready_when_drain, i_out_ready, o_in_ready)

    // Reset leaves no result pending
    `TTS_ASSERT_ALWAYS_NEXT(a_reset_clears, !i_rst_n, !o_out_valid)

endmodule

bind texture_texel_sampler_core tts_checker u_tts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_argb      (o_argb)
);

/* dv/tb_top.sv */
module tb_top;
    import tts_pkg::*;

    localparam int TEX_WORDS    = 65536;
    localparam int FRAC_BITS    = 16;
    localparam logic [31:0] FIX_ONE    = 32'd1 << FRAC_BITS;
    localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;
    // Highest format code, one of the codes that decode to white
    localparam logic [2:0] FMT_UNKNOWN_HI = 3'd7;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_op;
    logic signed [31:0] i_coord_u;
    logic signed [31:0] i_coord_v;
    logic [15:0] i_load_address;
    logic [15:0] i_load_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_argb;

    texture_texel_sampler_core #(
        .TEX_WORDS(TEX_WORDS),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_op(i_op),
        .i_coord_u(i_coord_u),
        .i_coord_v(i_coord_v),
        .i_load_address(i_load_address),
        .i_load_data(i_load_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_argb(o_argb)
    );

    // Shadow copy of the sampler state
    t_wrap_mode  cfg_wrap_u = WRAP_CYL;
    t_wrap_mode  cfg_wrap_v = WRAP_CYL;
    logic [3:0]  cfg_size   = '0;
    logic [2:0]  cfg_format = '0;
    logic [15:0] cfg_base   = '0;
    logic [15:0] texel_mem    [0:TEX_WORDS-1];
    bit          texel_loaded [0:TEX_WORDS-1];

    logic [31:0] argb_expected[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fold a raw coordinate into 0..1 per wrap mode
    function automatic logic [31:0] fold_to_unit(logic [31:0] raw, t_wrap_mode mode);
        logic [31:0] c;
        case (mode)
            WRAP_MIRROR: begin
                c = raw & (2 * FIX_ONE - 1);
                if (c > FIX_ONE)
                    c = 2 * FIX_ONE - c;
            end
            WRAP_CLAMP: c = raw[31] ? 32'd0 : ((raw > FIX_ONE) ? FIX_ONE : raw);
            default:    c = raw & (FIX_ONE - 1);
        endcase
        return c;
    endfunction

    // Store word address hit by a sample under the current setup
    function automatic logic [15:0] texel_word_addr(logic [31:0] u_raw, logic [31:0] v_raw);
        logic [63:0] side;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] sum;
        side = 64'd1 << cfg_size;
        x = ((64'(fold_to_unit(u_raw, cfg_wrap_u)) * side) >> FRAC_BITS) & (side - 1);
        y = ((64'(fold_to_unit(v_raw, cfg_wrap_v)) * side) >> FRAC_BITS) & (side - 1);
        sum = 64'(cfg_base) + y * side + x;
        return 16'(sum % TEX_WORDS);
    endfunction

    // Expand a stored texel word to ARGB8888
    function automatic logic [31:0] expand_to_argb(logic [15:0] t, logic [2:0] fmt);
        case (fmt)
            FMT_A1R5G5B5: return {{8{t[15]}}, t[14:10], 3'b0, t[9:5], 3'b0, t[4:0], 3'b0};
            FMT_X1R5G5B5: return {8'hFF, t[14:10], 3'b0, t[9:5], 3'b0, t[4:0], 3'b0};
            FMT_A4R4G4B4: return {t[15:12], 4'b0, t[11:8], 4'b0, t[7:4], 4'b0, t[3:0], 4'b0};
            FMT_R5G6B5:   return {8'hFF, t[15:11], 3'b0, t[10:5], 2'b0, t[4:0], 3'b0};
            default:      return ARGB_WHITE;
        endcase
    endfunction

    // Random coordinate: full range, near 0..1, or a corner value
    function automatic logic [31:0] pick_coord();
        int sel;
        logic [31:0] c;
        sel = $urandom_range(9);
        if (sel < 3) begin
            c = $urandom;
        end else if (sel < 7) begin
            c = 32'($urandom_range(32'h4_0000)) - 32'h2_0000;
        end else if (sel < 8) begin
            case ($urandom_range(7))
                0: c = 32'd0;
                1: c = FIX_ONE;
                2: c = 2 * FIX_ONE;
                3: c = -FIX_ONE;
                4: c = 32'h7FFF_FFFF;
                5: c = 32'h8000_0000;
                6: c = FIX_ONE - 1;
                default: c = FIX_ONE + 1;
            endcase
        end else begin
            c = 32'($urandom_range(FIX_ONE));
        end
        return c;
    endfunction

    // Random upper bits above a register value, which the block must ignore
    function automatic logic [15:0] with_noise(logic [15:0] val, int bits);
        logic [15:0] keep;
        keep = (16'd1 << bits) - 16'd1;
        return (16'($urandom) & ~keep) | (val & keep);
    endfunction

    // Item transfer; the shadow state is updated at the accepting edge
    task automatic send_item(input logic op, input logic [31:0] u, input logic [31:0] v,
                             input logic [15:0] la, input logic [15:0] ld);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_coord_u      <= u;
        i_coord_v      <= v;
        i_load_address <= la;
        i_load_data    <= ld;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        if (op == OP_LOAD) begin
            texel_mem[la]    = ld;
            texel_loaded[la] = 1'b1;
        end else begin
            argb_expected.push_back(
                expand_to_argb(texel_mem[texel_word_addr(u, v)], cfg_format));
        end
    endtask

    task automatic load_word(input logic [15:0] addr, input logic [15:0] data);
        send_item(OP_LOAD, $urandom, $urandom, addr, data);
    endtask

    // Sample, loading the addressed word first if it was never written
    task automatic sample_item(input logic [31:0] u, input logic [31:0] v);
        logic [15:0] a;
        a = texel_word_addr(u, v);
        if (!texel_loaded[a])
            load_word(a, 16'($urandom));
        send_item(OP_SAMPLE, u, v, 16'($urandom), 16'($urandom));
    endtask

    // Stop offering items, wait for all results and let the pipeline empty
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (argb_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write transfer
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        case (idx)
            CFG_WRAP_U:   cfg_wrap_u = t_wrap_mode'(data[1:0]);
            CFG_WRAP_V:   cfg_wrap_v = t_wrap_mode'(data[1:0]);
            CFG_SIZE:     cfg_size   = data[3:0];
            CFG_FORMAT:   cfg_format = data[2:0];
            CFG_TEX_BASE: cfg_base   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random setup, sizes mostly small
    task automatic program_random_setup();
        logic [3:0]  sz;
        logic [15:0] base;
        logic [2:0]  fmt;
        case ($urandom_range(9))
            7, 8:    sz = 4'($urandom_range(5, 11));
            9:       sz = 4'($urandom_range(12, 15));
            default: sz = 4'($urandom_range(4));
        endcase
        case ($urandom_range(3))
            0:       base = 16'h0000;
            1:       base = 16'hFFFF;
            default: base = 16'($urandom);
        endcase
        fmt = ($urandom_range(99) < 75) ? 3'($urandom_range(3)) : 3'($urandom_range(4, 7));
        write_reg(CFG_WRAP_U, with_noise(16'($urandom_range(3)), 2));
        write_reg(CFG_WRAP_V, with_noise(16'($urandom_range(3)), 2));
        write_reg(CFG_SIZE, with_noise(16'(sz), 4));
        write_reg(CFG_FORMAT, with_noise(16'(fmt), 3));
        write_reg(CFG_TEX_BASE, base);
        // unused indexes must leave the setup alone
        if ($urandom_range(3) == 0)
            write_reg(3'(CFG_TEX_BASE + 1 + $urandom_range(2)), 16'($urandom));
    endtask

    // Load inside the current texture, load anywhere, or sample
    task automatic random_item();
        int unsigned side;
        logic [15:0] a;
        if ($urandom_range(99) < 35) begin
            if ($urandom_range(1) == 1) begin
                side = 32'd1 << cfg_size;
                a = 16'(cfg_base + $urandom_range(side * side - 1));
            end else begin
                a = 16'($urandom);
            end
            load_word(a, 16'($urandom));
        end else begin
            sample_item(pick_coord(), pick_coord());
        end
    endtask

    // Reset setup: side 1 at base 0, every sample reads word 0
    task automatic test_reset_defaults();
        load_word(16'h0000, 16'hFFFF);
        load_word(16'hFFFF, 16'hA5C3);
        sample_item(32'h0000_0000, 32'h0000_0000);
        sample_item(32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    // Each texel format on one word, unknown codes give white
    task automatic test_texel_formats();
        logic [2:0] fmts[5];
        fmts = '{FMT_A1R5G5B5, FMT_X1R5G5B5, FMT_A4R4G4B4, FMT_R5G6B5, FMT_UNKNOWN_HI};
        wait_idle();
        write_reg(CFG_TEX_BASE, 16'hFFFF);
        foreach (fmts[i]) begin
            wait_idle();
            write_reg(CFG_FORMAT, 16'(fmts[i]));
            sample_item($urandom, $urandom);
        end
    endtask

    // Negative mirror, clamp at exactly one and below zero, negative wrap
    task automatic test_wrap_modes();
        t_wrap_mode  modes[4];
        logic [31:0] us[4];
        logic [31:0] vs[4];
        modes = '{WRAP_MIRROR, WRAP_CLAMP, WRAP_REPEAT, WRAP_CYL};
        us    = '{-32'h8000, FIX_ONE, -32'h4000, 32'h8000_0000};
        vs    = '{32'h1_8000, -32'h4000, 32'h7FFF_FFFF, 32'h1_FFFF};
        wait_idle();
        write_reg(CFG_SIZE, 16'd2);
        write_reg(CFG_TEX_BASE, 16'h0000);
        write_reg(CFG_FORMAT, 16'(FMT_R5G6B5));
        foreach (modes[i]) begin
            wait_idle();
            write_reg(CFG_WRAP_U, 16'(modes[i]));
            write_reg(CFG_WRAP_V, 16'(modes[i]));
            sample_item(us[i], vs[i]);
        end
    endtask

    // Largest nominal size, then size 15 past it with base wraparound
    task automatic test_size_extremes();
        wait_idle();
        write_reg(CFG_SIZE, 16'd11);
        write_reg(CFG_TEX_BASE, 16'h1234);
        write_reg(CFG_FORMAT, 16'(FMT_A4R4G4B4));
        sample_item(32'h0000_FFFF, 32'hFFFF_0000);
        wait_idle();
        write_reg(CFG_SIZE, 16'd15);
        write_reg(CFG_TEX_BASE, 16'hFFFF);
        write_reg(CFG_WRAP_U, 16'(WRAP_CLAMP));
        write_reg(CFG_WRAP_V, 16'(WRAP_MIRROR));
        sample_item(32'h7FFF_FFFF, 32'hFFFF_8000);
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int stall_pct);
        int done;
        int group_left;
        done = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (done < n_items) begin
            wait_idle();
            program_random_setup();
            group_left = $urandom_range(20, 60);
            while (group_left > 0 && done < n_items) begin
                random_item();
                group_left--;
                done++;
            end
        end
    endtask

    // Long output hold-off with the sender pushing back to back
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        write_reg(CFG_SIZE, 16'd3);
        write_reg(CFG_TEX_BASE, 16'($urandom));
        write_reg(CFG_FORMAT, 16'(FMT_A1R5G5B5));
        hold_req = 1'b1;
        repeat (80) sample_item(pick_coord(), pick_coord());
    endtask

    // Output ready: random stalls plus the requested hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (argb_expected.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: argb=%h", o_argb);
                mismatches++;
            end else begin
                if (o_argb !== argb_expected[0]) begin
                    if (mismatches < MAX_REPORTS)
                        $display("argb mismatch: expected %h actual %h",
                                 argb_expected[0], o_argb);
                    mismatches++;
                end
                void'(argb_expected.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_op           = OP_LOAD;
        i_coord_u      = '0;
        i_coord_v      = '0;
        i_load_address = '0;
        i_load_data    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_texel_formats();
        test_wrap_modes();
        test_size_extremes();
        test_random(150, 0, 0);
        test_random(90, 85, 0);
        test_backpressure();
        test_random(90, 0, 85);
        test_random(140, 17, 17);
        wait_idle();

        if (mismatches == 0 && argb_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
